>>> sv/lsco_pkg.sv
// Shared types and constants for the LED strip cursor overlay.
package lsco_pkg;

  localparam int COLOR_W = 24;
  localparam int POS_W   = 20;
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 7;
  localparam int LEN_W   = 8;

  // APB register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_FULL_SCALE = 1'b0;  // register select, paddr[2]

  localparam logic [POS_W-1:0] FULL_SCALE_RESET = 20'd10000;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_TRACK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FILL     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ     = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   motor_position;
    logic [COLOR_W-1:0] pixel_value;
    logic               leave_trail;
    logic [IDX_W-1:0]   range_start;
    logic [LEN_W-1:0]   range_length;
    logic [IDX_W-1:0]   read_index;
  } cmd_t;

endpackage

>>> sv/lsco_frame_mem.sv
// Frame store: one write port, one registered read port.
module lsco_frame_mem import lsco_pkg::*; #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [COLOR_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/lsco_divider.sv
// Position to window start: saturate, multiply by span, restoring divide by full scale.
module lsco_divider import lsco_pkg::*; #(
  parameter int STRIP_PIXELS  = 128,
  parameter int WINDOW_PIXELS = 4,
  localparam int AW = $clog2(STRIP_PIXELS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [POS_W-1:0] pos,
  input  logic [POS_W-1:0] fs,
  output logic             done,
  output logic [AW-1:0]    quot
);

  localparam int SPAN = (STRIP_PIXELS > WINDOW_PIXELS) ? STRIP_PIXELS - WINDOW_PIXELS : 0;
  localparam int PW   = POS_W + AW;
  localparam int SW   = $clog2(AW);
  localparam logic [SW-1:0] STEP_LAST = SW'(AW - 1);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MULT = 4'b0010,
    D_LOAD = 4'b0100,
    D_RUN  = 4'b1000
  } div_state_t;

  div_state_t       phase;
  logic [POS_W-1:0] num;
  logic [POS_W-1:0] den;
  logic [PW-1:0]    prod;
  logic [POS_W-1:0] rem;
  logic [AW-1:0]    sh;
  logic [AW-1:0]    q;
  logic [SW-1:0]    step;
  logic [POS_W:0]   trial;
  logic             fits;

  // quotient < 2^AW, so only AW steps; remainder stays below den
  assign trial = {rem, sh[AW-1]};
  assign fits  = (trial >= {1'b0, den});
  assign quot  = (den == '0) ? '0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        D_IDLE: begin
          if (start) begin
            num   <= (pos > fs) ? fs : pos;
            den   <= fs;
            phase <= D_MULT;
          end
        end
        D_MULT: begin
          prod  <= PW'(num) * PW'(SPAN);
          phase <= D_LOAD;
        end
        D_LOAD: begin
          rem   <= prod[PW-1:AW];
          sh    <= prod[AW-1:0];
          q     <= '0;
          step  <= '0;
          phase <= D_RUN;
        end
        D_RUN: begin
          if (fits) begin
            rem <= POS_W'(trial - {1'b0, den});
          end else begin
            rem <= trial[POS_W-1:0];
          end
          q  <= {q[AW-2:0], fits};
          sh <= {sh[AW-2:0], 1'b0};
          if (step == STEP_LAST) begin
            phase <= D_IDLE;
            done  <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: phase <= D_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lsco_ctrl.sv
// Command sequencer: walks the frame store, takes a new command only when idle, keeps cursor and saved pixels.
module lsco_ctrl import lsco_pkg::*; #(
  parameter int STRIP_PIXELS  = 128,
  parameter int WINDOW_PIXELS = 4,
  localparam int AW = $clog2(STRIP_PIXELS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               launch,
  input  cmd_t               cmd_in,
  output logic               busy,
  output logic               done,
  output logic [COLOR_W-1:0] read_color,
  output logic [IDX_W-1:0]   cursor_start,
  // frame store
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [COLOR_W-1:0] mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [COLOR_W-1:0] mem_rdata,
  // divider
  output logic               div_start,
  output logic [POS_W-1:0]   div_pos,
  input  logic               div_done,
  input  logic [AW-1:0]      div_quot
);

  localparam int XW   = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int AW1  = AW + 1;
  localparam int WIW  = (WINDOW_PIXELS > 1) ? $clog2(WINDOW_PIXELS) : 1;
  localparam int WRAP = (STRIP_PIXELS / 2 > WINDOW_PIXELS / 2) ?
                        STRIP_PIXELS / 2 - WINDOW_PIXELS / 2 : 0;

  localparam logic [XW-1:0]  STRIP_X     = XW'(STRIP_PIXELS);
  localparam logic [XW-1:0]  WIN_LAST    = XW'(WINDOW_PIXELS - 1);
  localparam logic [XW-1:0]  WIN_CNT     = XW'(WINDOW_PIXELS);
  localparam logic [XW-1:0]  PAIR_LAST   = XW'(2 * WINDOW_PIXELS - 1);
  localparam logic [XW-1:0]  STRIP_LAST  = XW'(STRIP_PIXELS - 1);
  localparam logic [AW-1:0]  MIRROR_BASE = AW'(STRIP_PIXELS - 1);
  localparam logic [AW1-1:0] WRAP_X      = AW1'(WRAP);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_RESTORE   = 11'b000_0000_0010,
    S_DIV       = 11'b000_0000_0100,
    S_SAVE      = 11'b000_0000_1000,
    S_BLANK     = 11'b000_0001_0000,
    S_ADVANCE   = 11'b000_0010_0000,
    S_SWEEP     = 11'b000_0100_0000,
    S_PAINT     = 11'b000_1000_0000,
    S_FILL      = 11'b001_0000_0000,
    S_READ      = 11'b010_0000_0000,
    S_READ_WAIT = 11'b100_0000_0000
  } state_t;

  state_t             state;
  cmd_t               cmd;
  logic [XW-1:0]      cnt;
  logic [AW-1:0]      ws;
  logic [COLOR_W-1:0] saved [WINDOW_PIXELS];
  logic               sweep_paint;

  logic [XW-1:0]      step_off;
  logic [XW-1:0]      win_idx;
  logic               win_ok;
  logic [XW-1:0]      save_rd_idx;
  logic               save_rd_ok;
  logic [XW-1:0]      fill_idx;
  logic               fill_ok;
  logic               fill_end;
  logic               read_ok;
  logic [AW-1:0]      pair_addr;
  logic [WIW-1:0]     sv_idx;
  logic [AW1-1:0]     ws_inc;

  always_comb begin
    unique case (state) inside
      S_SAVE:           step_off = cnt - 1'b1;   // write side trails the read by one
      S_BLANK, S_PAINT: step_off = cnt >> 1;     // even: pixel, odd: mirror
      default:          step_off = cnt;
    endcase
  end

  assign win_idx     = XW'(ws) + step_off;
  assign win_ok      = (win_idx < STRIP_X);
  assign save_rd_idx = XW'(ws) + cnt;
  assign save_rd_ok  = (save_rd_idx < STRIP_X);
  assign fill_idx    = XW'(cmd.range_start) + cnt;
  assign fill_ok     = (fill_idx < STRIP_X);
  assign fill_end    = (cnt == XW'(cmd.range_length)) || !fill_ok;
  assign read_ok     = (XW'(cmd.read_index) < STRIP_X);
  assign pair_addr   = cnt[0] ? (MIRROR_BASE - win_idx[AW-1:0]) : win_idx[AW-1:0];
  assign sv_idx      = step_off[WIW-1:0];
  assign ws_inc      = AW1'(ws) + 1'b1;

  assign busy         = (state != S_IDLE);
  assign cursor_start = IDX_W'(ws);
  assign div_start    = (state == S_RESTORE) && (cnt == WIN_LAST);
  assign div_pos      = cmd.motor_position;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_RESTORE: begin
        mem_we    = win_ok;
        mem_waddr = win_idx[AW-1:0];
        mem_wdata = saved[sv_idx];
      end
      S_SAVE: begin
        mem_we    = (cnt != '0) && win_ok;
        mem_waddr = win_idx[AW-1:0];
        mem_wdata = cmd.pixel_value;
        mem_re    = (cnt < WIN_CNT) && save_rd_ok;
        mem_raddr = save_rd_idx[AW-1:0];
      end
      S_BLANK: begin
        mem_we    = win_ok;
        mem_waddr = pair_addr;
      end
      S_PAINT: begin
        mem_we    = win_ok;
        mem_waddr = pair_addr;
        mem_wdata = cmd.pixel_value;
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
      end
      S_FILL: begin
        mem_we    = !fill_end;
        mem_waddr = fill_idx[AW-1:0];
        mem_wdata = cmd.pixel_value;
      end
      S_READ: begin
        mem_re    = read_ok;
        mem_raddr = AW'(cmd.read_index);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;   // clear the frame store after reset
      cnt         <= '0;
      ws          <= '0;
      sweep_paint <= 1'b0;
      done        <= 1'b0;
      read_color  <= '0;
      for (int i = 0; i < WINDOW_PIXELS; i++) begin
        saved[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (launch) begin
            cmd <= cmd_in;
            cnt <= '0;
            case (cmd_in.mode)
              MODE_TRACK:    state <= S_RESTORE;
              MODE_COMPLETE: state <= cmd_in.leave_trail ? S_ADVANCE : S_BLANK;
              MODE_CLEAR: begin
                ws         <= '0;
                done       <= 1'b1;
                read_color <= '0;
              end
              MODE_FILL:     state <= S_FILL;
              MODE_READ:     state <= S_READ;
              default: begin
                done       <= 1'b1;
                read_color <= '0;
              end
            endcase
          end
        end
        S_RESTORE: begin
          if (cnt == WIN_LAST) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ws    <= div_quot;
            state <= S_SAVE;
          end
        end
        S_SAVE: begin
          if (cnt != '0) begin
            saved[sv_idx] <= win_ok ? mem_rdata : '0;
          end
          if (cnt == WIN_CNT) begin
            cnt        <= '0;
            state      <= S_IDLE;
            done       <= 1'b1;
            read_color <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BLANK: begin
          if (cnt == PAIR_LAST) begin
            cnt   <= '0;
            state <= S_ADVANCE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ADVANCE: begin
          if (ws_inc >= WRAP_X) begin
            ws <= '0;
            if (cmd.leave_trail) begin
              sweep_paint <= 1'b1;
              state       <= S_SWEEP;
            end else begin
              state <= S_PAINT;
            end
          end else begin
            ws    <= ws_inc[AW-1:0];
            state <= S_PAINT;
          end
        end
        S_SWEEP: begin
          if (cnt == STRIP_LAST) begin
            cnt         <= '0;
            sweep_paint <= 1'b0;
            state       <= sweep_paint ? S_PAINT : S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PAINT: begin
          if (cnt == PAIR_LAST) begin
            cnt        <= '0;
            state      <= S_IDLE;
            done       <= 1'b1;
            read_color <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FILL: begin
          if (fill_end) begin
            cnt        <= '0;
            state      <= S_IDLE;
            done       <= 1'b1;
            read_color <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_READ: state <= S_READ_WAIT;
        S_READ_WAIT: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          read_color <= read_ok ? mem_rdata : '0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/led_strip_cursor_overlay_unit.sv
// Top level of the LED strip cursor overlay: config register, sequencer, frame store, divider.
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------------
//  command   | start, busy, mode .. read_index                | word taken when start & !busy
//  result    | done, read_color, cursor_start                 | one-cycle strobe, no stall
//  config    | psel penable pwrite paddr pwdata prdata pready | APB, write on access phase
//
// The single frame store write port sets most of the run time of a word, and the
// bit-per-cycle divider sets that of track; a complete step with a trail that wraps
// also sweeps the whole strip, and clear and unknown modes answer without raising busy.
// After reset the frame store is swept to black with busy high.
// The result strobe cannot be held off; busy drops in the strobe cycle.
module led_strip_cursor_overlay_unit import lsco_pkg::*; #(
  parameter int STRIP_PIXELS  = 128,
  parameter int WINDOW_PIXELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  // command
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [POS_W-1:0]   motor_position,
  input  logic [COLOR_W-1:0] pixel_value,
  input  logic               leave_trail,
  input  logic [IDX_W-1:0]   range_start,
  input  logic [LEN_W-1:0]   range_length,
  input  logic [IDX_W-1:0]   read_index,
  // result
  output logic               done,
  output logic [COLOR_W-1:0] read_color,
  output logic [IDX_W-1:0]   cursor_start,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(STRIP_PIXELS);

  logic [POS_W-1:0]   full_scale;
  logic               cfg_wr;
  logic               launch;
  cmd_t               cmd;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COLOR_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [COLOR_W-1:0] mem_rdata;

  logic               div_start;
  logic [POS_W-1:0]   div_pos;
  logic               div_done;
  logic [AW-1:0]      div_quot;

  // APB: pready tied high; one register, selected by paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FULL_SCALE);
  assign prdata = (paddr[2] == REG_FULL_SCALE) ? PDATA_W'(full_scale) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RESET;
    end else if (cfg_wr) begin
      full_scale <= pwdata[POS_W-1:0];
    end
  end

  assign launch = start && !busy;

  always_comb begin
    cmd.mode           = mode;
    cmd.motor_position = motor_position;
    cmd.pixel_value    = pixel_value;
    cmd.leave_trail    = leave_trail;
    cmd.range_start    = range_start;
    cmd.range_length   = range_length;
    cmd.read_index     = read_index;
  end

  lsco_frame_mem #(
    .DEPTH (STRIP_PIXELS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lsco_divider #(
    .STRIP_PIXELS  (STRIP_PIXELS),
    .WINDOW_PIXELS (WINDOW_PIXELS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .pos   (div_pos),
    .fs    (full_scale),
    .done  (div_done),
    .quot  (div_quot)
  );

  lsco_ctrl #(
    .STRIP_PIXELS  (STRIP_PIXELS),
    .WINDOW_PIXELS (WINDOW_PIXELS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .launch       (launch),
    .cmd_in       (cmd),
    .busy         (busy),
    .done         (done),
    .read_color   (read_color),
    .cursor_start (cursor_start),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .div_start    (div_start),
    .div_pos      (div_pos),
    .div_done     (div_done),
    .div_quot     (div_quot)
  );

endmodule

>>> sv/lsco_checker.sv
// Port-level checks for the cursor overlay, bound to the top level.
module lsco_checker import lsco_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [MODE_W-1:0]  mode,
  input logic               done,
  input logic [COLOR_W-1:0] read_color,
  input logic [IDX_W-1:0]   cursor_start
);

  logic              pending;
  logic [MODE_W-1:0] last_mode;
  logic              accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      last_mode <= MODE_TRACK;
    end else begin
      if (accept) begin
        pending   <= 1'b1;
        last_mode <= mode;
      end else if (done) begin
        pending <= 1'b0;
      end
    end
  end

  a_done_has_word: assert property (@(posedge clk) disable iff (rst) done |-> pending)
    else $error("result strobe without an outstanding word");

  a_color_zero: assert property (@(posedge clk) disable iff (rst)
    (done && last_mode != MODE_READ) |-> (read_color == '0))
    else $error("nonzero read_color outside read mode");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (done && last_mode == MODE_CLEAR) |-> (cursor_start == '0))
    else $error("clear did not return cursor to zero");

  a_reset_sweep: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_long_modes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_TRACK || mode == MODE_COMPLETE ||
                mode == MODE_FILL || mode == MODE_READ)) |=> busy)
    else $error("multi-cycle mode did not raise busy");

endmodule

bind led_strip_cursor_overlay_unit lsco_checker u_lsco_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .mode         (mode),
  .done         (done),
  .read_color   (read_color),
  .cursor_start (cursor_start)
);

>>> tb/led_strip_cursor_overlay_unit_test.sv
// Self-checking testbench for the LED strip cursor overlay: directed table, then random traffic.
module led_strip_cursor_overlay_unit_test import lsco_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the block as built (parameters left at their defaults).
  localparam int STRIP = 128;
  localparam int WIN   = 4;
  localparam int SPAN  = STRIP - WIN;          // last window start
  localparam int WRAP  = STRIP / 2 - WIN / 2;  // complete-mode wrap point

  // Modes the block must ignore; it still answers with a word.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Longest quiet stretch the block can need after its last word (trail wrap).
  localparam int TAIL_CYCLES = 4 * WIN + 2 + STRIP + 16;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   cursor;
  } strip_answer_t;

  // One line of the directed table: a config write or a command word.
  typedef struct {
    bit                 is_cfg;
    logic [POS_W-1:0]   scale;
    cmd_t               word;
    bit                 typed;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   cursor;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  logic               start;
  logic               busy;
  logic [MODE_W-1:0]  mode;
  logic [POS_W-1:0]   motor_position;
  logic [COLOR_W-1:0] pixel_value;
  logic               leave_trail;
  logic [IDX_W-1:0]   range_start;
  logic [LEN_W-1:0]   range_length;
  logic [IDX_W-1:0]   read_index;
  logic               done;
  logic [COLOR_W-1:0] read_color;
  logic [IDX_W-1:0]   cursor_start;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  led_strip_cursor_overlay_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .motor_position (motor_position),
    .pixel_value    (pixel_value),
    .leave_trail    (leave_trail),
    .range_start    (range_start),
    .range_length   (range_length),
    .read_index     (read_index),
    .done           (done),
    .read_color     (read_color),
    .cursor_start   (cursor_start),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: frame store, pixels saved under the track window,
  // window start and the full-scale register.
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] strip_img [STRIP];
  logic [COLOR_W-1:0] under_win [WIN];
  int unsigned        win_at;
  logic [POS_W-1:0]   full_scale;

  strip_answer_t strip_answers[$];  // words still owed by the block

  // Expectation typed into the directed table for the word being offered.
  bit                 typed_on;
  logic [COLOR_W-1:0] typed_col;
  logic [IDX_W-1:0]   typed_cur;

  int accepted;      // command words taken
  int cfg_writes;    // register writes seen
  int mismatches;
  int strip_wipes;   // trail wraps that blanked the strip
  int mode_hits [8];

  function automatic void put_px(input int unsigned idx, input logic [COLOR_W-1:0] c);
    if (idx < STRIP) strip_img[idx] = c;
  endfunction

  function automatic logic [COLOR_W-1:0] get_px(input int unsigned idx);
    return (idx < STRIP) ? strip_img[idx] : '0;
  endfunction

  // Mirror counts from the far end; indexes off the strip are dropped.
  function automatic void put_mirror(input int unsigned idx, input logic [COLOR_W-1:0] c);
    if (idx < STRIP) strip_img[STRIP - 1 - idx] = c;
  endfunction

  // Applies one command word to the shadow and returns the word it answers with.
  function automatic void overlay_apply(input cmd_t c, output logic [COLOR_W-1:0] col,
                                        output logic [IDX_W-1:0] cur);
    logic [POS_W-1:0] pos;
    longint unsigned  prod;
    col = '0;
    case (c.mode)
      MODE_TRACK: begin
        pos = (c.motor_position > full_scale) ? full_scale : c.motor_position;
        // put back what the old window covered, then move and save again
        for (int i = 0; i < WIN; i++) put_px(win_at + i, under_win[i]);
        prod = longint'(pos) * SPAN;
        win_at = (full_scale == '0) ? 0 : int'(prod / full_scale);
        for (int i = 0; i < WIN; i++) begin
          under_win[i] = get_px(win_at + i);
          put_px(win_at + i, c.pixel_value);
        end
      end
      MODE_COMPLETE: begin
        if (!c.leave_trail) begin
          for (int i = 0; i < WIN; i++) begin
            put_px(win_at + i, '0);
            put_mirror(win_at + i, '0);
          end
        end
        win_at++;
        if (win_at >= WRAP) begin
          win_at = 0;
          if (c.leave_trail) begin
            for (int i = 0; i < STRIP; i++) strip_img[i] = '0;
            strip_wipes++;
          end
        end
        for (int i = 0; i < WIN; i++) begin
          put_px(win_at + i, c.pixel_value);
          put_mirror(win_at + i, c.pixel_value);
        end
      end
      MODE_CLEAR: win_at = 0;  // saved pixels stay
      MODE_FILL: begin
        for (int i = 0; i < c.range_length; i++) put_px(c.range_start + i, c.pixel_value);
      end
      MODE_READ: col = get_px(c.read_index);
      default: ;
    endcase
    cur = win_at[IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Edge monitor: everything here reads values settled before the edge.
  // Result check runs first, since a strobe and the next command can share an edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    cmd_t               w;
    strip_answer_t      want;
    logic [COLOR_W-1:0] pcol;
    logic [IDX_W-1:0]   pcur;
    if (rst) begin
      for (int i = 0; i < STRIP; i++) strip_img[i] = '0;
      for (int i = 0; i < WIN; i++) under_win[i] = '0;
      win_at = 0;
      full_scale = FULL_SCALE_RESET;
      strip_answers.delete();
    end else begin
      if (done) begin
        if (strip_answers.size() == 0) begin
          $error("result word with nothing outstanding: read_color %h cursor_start %0d",
                 read_color, cursor_start);
          mismatches++;
        end else begin
          want = strip_answers.pop_front();
          if (read_color !== want.color) begin
            $error("read_color: expected %h, got %h", want.color, read_color);
            mismatches++;
          end
          if (cursor_start !== want.cursor) begin
            $error("cursor_start: expected %0d, got %0d", want.cursor, cursor_start);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        w = '{mode, motor_position, pixel_value, leave_trail, range_start, range_length,
              read_index};
        overlay_apply(w, pcol, pcur);
        // typed rows override the shadow's answer
        want = typed_on ? strip_answer_t'{typed_col, typed_cur}
                        : strip_answer_t'{pcol, pcur};
        strip_answers.push_back(want);
        mode_hits[w.mode]++;
        accepted++;
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_FULL_SCALE) begin
        full_scale = pwdata[POS_W-1:0];
        cfg_writes++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: all called at a falling edge and return at one.
  // ---------------------------------------------------------------------------

  // Offers one word after an optional gap and holds it until taken. start is
  // left high so the next word can follow without a bubble.
  task automatic issue(input cmd_t c, input int gap, input bit typed = 1'b0,
                       input logic [COLOR_W-1:0] tcol = '0,
                       input logic [IDX_W-1:0] tcur = '0);
    int taken;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_on       = typed;
    typed_col      = tcol;
    typed_cur      = tcur;
    mode           = c.mode;
    motor_position = c.motor_position;
    pixel_value    = c.pixel_value;
    leave_trail    = c.leave_trail;
    range_start    = c.range_start;
    range_length   = c.range_length;
    read_index     = c.read_index;
    start          = 1'b1;
    taken = accepted;
    do @(negedge clk); while (accepted == taken);
  endtask

  // Drops start and waits for every owed word.
  task automatic drain();
    start = 1'b0;
    while (strip_answers.size() != 0) @(negedge clk);
  endtask

  // APB write of the full-scale register; junk in the unused upper data bits.
  task automatic cfg_write(input logic [POS_W-1:0] v);
    int seen;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_FULL_SCALE, 2'b00};
    pwdata  = $urandom;
    pwdata[POS_W-1:0] = v;
    seen = cfg_writes;
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (cfg_writes == seen);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic plan_row_t cmd_row(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                                        input logic [COLOR_W-1:0] col, input logic tr,
                                        input logic [IDX_W-1:0] rs, input logic [LEN_W-1:0] rl,
                                        input logic [IDX_W-1:0] ri, input bit typed = 1'b0,
                                        input logic [COLOR_W-1:0] ecol = '0,
                                        input logic [IDX_W-1:0] ecur = '0);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.scale  = '0;
    r.word   = '{m, p, col, tr, rs, rl, ri};
    r.typed  = typed;
    r.color  = ecol;
    r.cursor = ecur;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [POS_W-1:0] v);
    plan_row_t r;
    r        = cmd_row(MODE_READ, '0, '0, 1'b0, '0, '0, '0);
    r.is_cfg = 1'b1;
    r.scale  = v;
    return r;
  endfunction

  // Random word with every field filled; the mode mix favors motion (track and complete).
  int   burst_left;
  logic burst_trail;

  function automatic cmd_t random_word();
    cmd_t c;
    int   r;
    int   hi;
    c.motor_position = POS_W'($urandom);
    c.pixel_value    = COLOR_W'($urandom);
    c.leave_trail    = 1'($urandom);
    c.range_start    = IDX_W'($urandom);
    c.range_length   = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(STRIP))
                                                : LEN_W'($urandom_range(12));
    c.read_index     = IDX_W'($urandom);
    if (burst_left == 0 && $urandom_range(99) < 4) begin
      // run of 20 to 70 complete steps, which can reach the wrap
      burst_left  = $urandom_range(70, 20);
      burst_trail = 1'($urandom);
    end
    if (burst_left > 0) begin
      burst_left--;
      c.mode = MODE_COMPLETE;
      if ($urandom_range(9) != 0) c.leave_trail = burst_trail;
      return c;
    end
    r = $urandom_range(99);
    if (r < 30) begin
      c.mode = MODE_TRACK;
      case ($urandom_range(3))
        0: ;                                                  // anywhere, mostly saturating
        3: begin                                              // around full scale
          hi = int'(full_scale) + int'($urandom_range(8));
          c.motor_position = (hi > int'(POS_MAX)) ? POS_MAX : POS_W'(hi);
        end
        default: c.motor_position = POS_W'($urandom_range(int'(full_scale)));
      endcase
    end else if (r < 55) c.mode = MODE_COMPLETE;
    else if (r < 70) c.mode = MODE_FILL;
    else if (r < 88) c.mode = MODE_READ;
    else if (r < 94) c.mode = MODE_CLEAR;
    else c.mode = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
    return c;
  endfunction

  // One random stretch under one full-scale setting; each offer cycle is
  // skipped with the given odds.
  task automatic random_phase(input int n, input int idle_pct, input logic [POS_W-1:0] fs);
    int gap;
    drain();
    cfg_write(fs);
    for (int k = 0; k < n; k++) begin
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      issue(random_word(), gap);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  plan_row_t plan[$];

  initial begin
    // known values on every input from time zero
    rst            = 1'b1;
    start          = 1'b0;
    mode           = MODE_READ;
    motor_position = '0;
    pixel_value    = '0;
    leave_trail    = 1'b0;
    range_start    = '0;
    range_length   = '0;
    read_index     = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    typed_on       = 1'b0;
    typed_col      = '0;
    typed_cur      = '0;
    burst_left     = 0;
    burst_trail    = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Typed rows can be read straight off the behavior; the
    // rest are checked against the shadow.
    // store is black after reset, both ends
    plan.push_back(cmd_row(MODE_READ, '0, '0, 1'b0, '0, '0, 7'd0, 1'b1, '0, 7'd0));
    plan.push_back(cmd_row(MODE_READ, '0, '0, 1'b0, '0, '0, 7'd127, 1'b1, '0, 7'd0));
    // track to the bottom, then saturate at the top
    plan.push_back(cmd_row(MODE_TRACK, '0, 24'hFFFFFF, 1'b0, '0, '0, '0, 1'b1, '0, 7'd0));
    plan.push_back(cmd_row(MODE_READ, '0, '0, 1'b0, '0, '0, 7'd0, 1'b1, 24'hFFFFFF, 7'd0));
    plan.push_back(cmd_row(MODE_TRACK, POS_MAX, 24'h000001, 1'b1, 7'd127, 8'd128, 7'd127,
                           1'b1, '0, 7'd124));
    plan.push_back(cmd_row(MODE_READ, '0, '0, 1'b0, '0, '0, 7'd0, 1'b1, '0, 7'd124));
    plan.push_back(cmd_row(MODE_READ, '0, '0, 1'b0, '0, '0, 7'd127, 1'b1, 24'h000001, 7'd124));
    // exactly full scale, then half way
    plan.push_back(cmd_row(MODE_TRACK, 20'd10000, 24'h800000, 1'b0, '0, '0, '0,
                           1'b1, '0, 7'd124));
    plan.push_back(cmd_row(MODE_TRACK, 20'd5000, 24'h123456, 1'b0, '0, '0, '0, 1'b1, '0, 7'd62));
    // complete steps from the wrap point, without and with trail
    plan.push_back(cmd_row(MODE_COMPLETE, '0, 24'hABCDEF, 1'b0, '0, '0, '0));
    plan.push_back(cmd_row(MODE_COMPLETE, '0, 24'h00FF00, 1'b1, '0, '0, '0));
    plan.push_back(cmd_row(MODE_CLEAR, POS_MAX, 24'hFFFFFF, 1'b1, 7'd127, 8'd128, 7'd127,
                           1'b1, '0, 7'd0));
    // fill running off the end, empty fill, whole-strip fill
    plan.push_back(cmd_row(MODE_FILL, '0, 24'hFF00FF, 1'b0, 7'd120, 8'd128, '0));
    plan.push_back(cmd_row(MODE_FILL, '0, 24'h777777, 1'b0, 7'd5, 8'd0, '0));
    plan.push_back(cmd_row(MODE_FILL, '0, 24'h0F0F0F, 1'b0, 7'd0, 8'd128, '0));
    plan.push_back(cmd_row(MODE_READ, '0, '0, 1'b0, '0, '0, 7'd127, 1'b1, 24'h0F0F0F, 7'd0));
    // unused modes leave everything alone
    plan.push_back(cmd_row(MODE_UNUSED_LO, POS_MAX, 24'hFFFFFF, 1'b1, 7'd127, 8'd128, 7'd127,
                           1'b1, '0, 7'd0));
    plan.push_back(cmd_row(MODE_UNUSED_HI, 20'd4000, 24'h5A5A5A, 1'b0, 7'd3, 8'd9, 7'd64,
                           1'b1, '0, 7'd0));
    // track after a clear puts the kept pixels back at start zero; then one
    // step short of the wrap and a trail step that wipes the strip
    plan.push_back(cmd_row(MODE_TRACK, 20'd4920, 24'h00FFFF, 1'b0, '0, '0, '0));
    plan.push_back(cmd_row(MODE_COMPLETE, '0, 24'h0000FF, 1'b1, '0, '0, '0));
    plan.push_back(cmd_row(MODE_READ, '0, '0, 1'b0, '0, '0, 7'd64));
    // full-scale extremes
    plan.push_back(cfg_row(20'd1));
    plan.push_back(cmd_row(MODE_TRACK, '0, 24'h102030, 1'b0, '0, '0, '0, 1'b1, '0, 7'd0));
    plan.push_back(cmd_row(MODE_TRACK, 20'd1, 24'h405060, 1'b0, '0, '0, '0, 1'b1, '0, 7'd124));
    plan.push_back(cmd_row(MODE_TRACK, 20'd777, 24'h708090, 1'b0, '0, '0, '0, 1'b1, '0, 7'd124));
    // zero full scale pins the window at zero
    plan.push_back(cfg_row(20'd0));
    plan.push_back(cmd_row(MODE_TRACK, 20'd5, 24'hA0B0C0, 1'b0, '0, '0, '0, 1'b1, '0, 7'd0));
    plan.push_back(cfg_row(POS_MAX));
    plan.push_back(cmd_row(MODE_TRACK, POS_MAX, 24'hC0FFEE, 1'b0, '0, '0, '0, 1'b1, '0, 7'd124));
    plan.push_back(cmd_row(MODE_COMPLETE, '0, 24'h00AA55, 1'b0, '0, '0, '0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        cfg_write(plan[i].scale);
      end else begin
        issue(plan[i].word, 0, plan[i].typed, plan[i].color, plan[i].cursor);
      end
    end

    // Random traffic: sender idles 34%, then 49%, then never; each stretch
    // split across two full-scale settings.
    random_phase(250, 34, POS_MAX);
    random_phase(250, 34, POS_W'($urandom_range(int'(POS_MAX), 1)));
    random_phase(250, 49, 20'd1);
    random_phase(250, 49, POS_W'($urandom_range(400, 1)));
    random_phase(250, 0, POS_W'(SPAN));
    random_phase(250, 0, POS_W'($urandom_range(int'(POS_MAX), 1)));

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d words: track %0d, complete %0d, clear %0d, fill %0d, read %0d, unused %0d",
             accepted, mode_hits[MODE_TRACK], mode_hits[MODE_COMPLETE], mode_hits[MODE_CLEAR],
             mode_hits[MODE_FILL], mode_hits[MODE_READ],
             accepted - mode_hits[MODE_TRACK] - mode_hits[MODE_COMPLETE]
             - mode_hits[MODE_CLEAR] - mode_hits[MODE_FILL] - mode_hits[MODE_READ]);
    $display("%0d full-scale writes, %0d trail wraps blanked the strip, %0d mismatches",
             cfg_writes, strip_wipes, mismatches);
    if (mismatches == 0) begin
      $display("led_strip_cursor_overlay_unit_test passed");
    end else begin
      $display("led_strip_cursor_overlay_unit_test failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(10_000_000);
    $display("led_strip_cursor_overlay_unit_test failed");
    $finish;
  end

endmodule
